// ===== hw/rtl/pste_pkg.sv =====
// Shared constants, register codes and helper functions of the power switch thermal estimator.
package pste_pkg;

  // Field widths of the sample, result and register channels.
  localparam int SAMPLE_BITS = 20;
  localparam int DEV_W       = 8;
  localparam int STEP_W      = 16;
  localparam int TIME_W      = 32;
  localparam int NOM_W       = 18;
  localparam int CLAMP_W     = 19;
  localparam int TEMP_W      = 24;
  localparam int RES0_W      = 20;
  localparam int RES_W       = 21;
  localparam int KCOOL_W     = 20;
  localparam int ALPHA_W     = 24;

  // Configuration channel.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_NOM_CURRENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOM_VOLTAGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_RES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COOLING     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd5;

  // Register values after reset.
  localparam logic [NOM_W-1:0]   NOM_CURRENT_RST = 18'd79155;
  localparam logic [NOM_W-1:0]   NOM_VOLTAGE_RST = 18'd48333;
  localparam logic [TEMP_W-1:0]  AMBIENT_RST     = 24'd76326;
  localparam logic [RES0_W-1:0]  BASE_RES_RST    = 20'd10486;
  localparam logic [KCOOL_W-1:0] COOLING_RST     = 20'd49152;
  localparam logic [ALPHA_W-1:0] ALPHA_RST       = 24'd33554;

  // Shared multiplier.
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // Exponential: one table factor per bit of the Q16 exponent.
  localparam int EXP_STEPS   = 32;
  localparam int X_W         = 32;
  localparam int EXP_BITS    = (EXP_STEPS < X_W) ? EXP_STEPS : X_W;
  localparam int EXP_IDX_W   = $clog2(EXP_BITS);
  localparam int EXP_TAB_LEN = 48;
  localparam int EXP_TAB_W   = $clog2(EXP_TAB_LEN);

  // Clamp a two's complement sample to 0..2x nominal.
  function automatic logic [CLAMP_W-1:0] clamp_sample(
    input logic [SAMPLE_BITS-1:0] raw,
    input logic [NOM_W-1:0]       nominal
  );
    localparam int CMP_W = (SAMPLE_BITS > CLAMP_W) ? SAMPLE_BITS : CLAMP_W;
    logic [CLAMP_W-1:0] limit;
    logic [CLAMP_W-1:0] result;
    limit = {nominal, 1'b0};
    if (raw[SAMPLE_BITS-1]) begin
      result = '0;
    end else if (CMP_W'(raw) > CMP_W'(limit)) begin
      result = limit;
    end else begin
      result = CLAMP_W'(raw);
    end
    return result;
  endfunction

  // exp(-2^(j-16)) in Q32; factors past index 20 round to zero.
  function automatic logic [MUL_W-1:0] exp_factor(input logic [EXP_TAB_W-1:0] idx);
    logic [MUL_W-1:0] f;
    case (idx)
      6'd0:    f = 32'd4294901760;
      6'd1:    f = 32'd4294836226;
      6'd2:    f = 32'd4294705160;
      6'd3:    f = 32'd4294443040;
      6'd4:    f = 32'd4293918848;
      6'd5:    f = 32'd4292870656;
      6'd6:    f = 32'd4290775039;
      6'd7:    f = 32'd4286586875;
      6'd8:    f = 32'd4278222805;
      6'd9:    f = 32'd4261543595;
      6'd10:   f = 32'd4228380000;
      6'd11:   f = 32'd4162825044;
      6'd12:   f = 32'd4034748382;
      6'd13:   f = 32'd3790295335;
      6'd14:   f = 32'd3344923893;
      6'd15:   f = 32'd2605029347;
      6'd16:   f = 32'd1580030169;
      6'd17:   f = 32'd581260615;
      6'd18:   f = 32'd78665070;
      6'd19:   f = 32'd1440801;
      6'd20:   f = 32'd483;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ===== hw/rtl/pste_cfg_if.sv =====
// Register write channel of the power switch thermal estimator.
interface pste_cfg_if import pste_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pste_in_if.sv =====
// Sample request channel of the power switch thermal estimator.
interface pste_in_if import pste_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [DEV_W-1:0]              device_id;
  logic [STEP_W-1:0]             step_number;
  logic [TIME_W-1:0]             sample_time;
  logic signed [SAMPLE_BITS-1:0] sample_current;
  logic signed [SAMPLE_BITS-1:0] sample_voltage;

  modport source (output valid, device_id, step_number, sample_time, sample_current,
                  sample_voltage, input ready);
  modport sink   (input valid, device_id, step_number, sample_time, sample_current,
                  sample_voltage, output ready);
endinterface

// ===== hw/rtl/pste_out_if.sv =====
// Result request channel of the power switch thermal estimator.
interface pste_out_if import pste_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DEV_W-1:0]   device_out;
  logic [STEP_W-1:0]  step_out;
  logic [TIME_W-1:0]  time_out;
  logic [CLAMP_W-1:0] clamped_current;
  logic [CLAMP_W-1:0] clamped_voltage;
  logic [TEMP_W-1:0]  temperature_out;
  logic [RES_W-1:0]   resistance_out;
  logic               current_high;
  logic               voltage_high;

  modport source (output valid, device_out, step_out, time_out, clamped_current,
                  clamped_voltage, temperature_out, resistance_out, current_high,
                  voltage_high, input ready);
  modport sink   (input valid, device_out, step_out, time_out, clamped_current,
                  clamped_voltage, temperature_out, resistance_out, current_high,
                  voltage_high, output ready);
endinterface

// ===== hw/rtl/power_switch_thermal_estimator.sv =====
// Top level of the power switch thermal estimator: sequencer, datapath and registers.
//
// One sample request is taken at a time and produces one result request. All products
// go through a single registered 32x32 multiplier under a small sequencer. Fixed
// multiply steps (SQ, KDT, RLO, RHI, CLO, CHI, HLO, HHI, HEAT) form power, cooling and
// heating, TEMP updates the temperature and XMUL and XGET form the exponent alpha*T. The
// exp(-alpha*T) loop then visits one exponent bit per cycle and spends an extra step
// (ERND) on each set bit after the first to round the product. RMUL and RFIN form the
// resistance, DONE commits the result and IDLE takes the next sample. The time from accept
// to accept grows with every set exponent bit beyond the first; the exponent loop sets
// the spread. The result sits in an output register, so a new sample is taken while the
// last result still waits; a sample that finishes while the previous result is still
// waiting holds until that result is taken, which adds those stall cycles. Register
// writes are taken only while no sample is in work, ahead of a waiting sample request,
// and apply from the next sample on.
module power_switch_thermal_estimator import pste_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pste_cfg_if.sink   cfg,
  pste_in_if.sink    samples,
  pste_out_if.source results
);

  // Working widths of the fixed-point datapath.
  localparam int SUM_W  = CLAMP_W + 1;
  localparam int SS_W   = 2 * SUM_W;
  localparam int KD_W   = KCOOL_W + TIME_W - 16;
  localparam int PS_W   = RES_W + SS_W;
  localparam int P_W    = PS_W - 26;
  localparam int CS_W   = KD_W + TEMP_W;
  localparam int CL_W   = CS_W - 16;
  localparam int HS_W   = P_W + TIME_W;
  localparam int HEAT_W = HS_W - 24;
  localparam int TC_W   = CL_W + 2;
  localparam int NT_W   = TC_W + 1;
  localparam int RE_W   = RES0_W + MUL_W;
  localparam int RS_W   = RES0_W + 34;

  // Sequencer states.
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SQ   = 5'd1;
  localparam logic [4:0] ST_KDT  = 5'd2;
  localparam logic [4:0] ST_RLO  = 5'd3;
  localparam logic [4:0] ST_RHI  = 5'd4;
  localparam logic [4:0] ST_CLO  = 5'd5;
  localparam logic [4:0] ST_CHI  = 5'd6;
  localparam logic [4:0] ST_HLO  = 5'd7;
  localparam logic [4:0] ST_HHI  = 5'd8;
  localparam logic [4:0] ST_HEAT = 5'd9;
  localparam logic [4:0] ST_TEMP = 5'd10;
  localparam logic [4:0] ST_XMUL = 5'd11;
  localparam logic [4:0] ST_XGET = 5'd12;
  localparam logic [4:0] ST_EXP  = 5'd13;
  localparam logic [4:0] ST_ERND = 5'd14;
  localparam logic [4:0] ST_RMUL = 5'd15;
  localparam logic [4:0] ST_RFIN = 5'd16;
  localparam logic [4:0] ST_DONE = 5'd17;

  logic [4:0] state;

  // Configuration registers.
  logic [NOM_W-1:0]   nom_i;
  logic [NOM_W-1:0]   nom_v;
  logic [TEMP_W-1:0]  amb;
  logic [RES0_W-1:0]  r0;
  logic [KCOOL_W-1:0] kcool;
  logic [ALPHA_W-1:0] alpha;

  // Model state carried from sample to sample.
  logic [TEMP_W-1:0]  temperature;
  logic [RES_W-1:0]   resistance;
  logic [CLAMP_W-1:0] prev_cur;
  logic [TIME_W-1:0]  last_time;

  // Per-sample working registers.
  logic [DEV_W-1:0]     dev;
  logic [STEP_W-1:0]    stepn;
  logic [TIME_W-1:0]    tm;
  logic [CLAMP_W-1:0]   cur;
  logic [CLAMP_W-1:0]   volt;
  logic                 cur_hi;
  logic                 volt_hi;
  logic [SUM_W-1:0]     s;
  logic [TIME_W-1:0]    dt;
  logic                 hot;
  logic [TEMP_W-1:0]    mag;
  logic [SS_W-1:0]      ss;
  logic [KD_W-1:0]      kd;
  logic [PROD_W-1:0]    acc;
  logic [P_W-1:0]       p;
  logic [CL_W-1:0]      cool;
  logic [TC_W-1:0]      tc;
  logic [HEAT_W-1:0]    heat;
  logic [TEMP_W-1:0]    tnew;
  logic [X_W-1:0]       x;
  logic [MUL_W-1:0]     e;
  logic                 e_one;
  logic [EXP_IDX_W-1:0] j;
  logic [RES_W-1:0]     rnew;

  // Output register.
  logic               out_valid;
  logic [DEV_W-1:0]   out_dev;
  logic [STEP_W-1:0]  out_step;
  logic [TIME_W-1:0]  out_time;
  logic [CLAMP_W-1:0] out_cur;
  logic [CLAMP_W-1:0] out_volt;
  logic [TEMP_W-1:0]  out_temp;
  logic [RES_W-1:0]   out_res;
  logic               out_cur_hi;
  logic               out_volt_hi;

  // Combinational values.
  logic               accept;
  logic               commit;
  logic [CLAMP_W-1:0] in_cur;
  logic [CLAMP_W-1:0] in_volt;
  logic [TIME_W-1:0]  in_dt;
  logic               in_hot;
  logic [TEMP_W-1:0]  in_mag;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  prod;
  logic [MUL_W-1:0]   fac;
  logic [PS_W-1:0]    p_sum;
  logic [CS_W-1:0]    cool_sum;
  logic [HS_W-1:0]    heat_sum;
  logic [TC_W-1:0]    t_ext;
  logic [TC_W-1:0]    cool_ext;
  logic [NT_W-1:0]    nt_sum;
  logic [TEMP_W-1:0]  t_sat;
  logic [X_W-1:0]     x_next;
  logic               x_ovf;
  logic [PROD_W-1:0]  e_rnd;
  logic [RE_W-1:0]    r0e;
  logic [RS_W-1:0]    r_sum;
  logic               j_last;

  // Handshakes. Register writes are taken only between samples and go ahead of a
  // waiting sample request, so a sample never sees a register change mid-way.
  assign cfg.ready     = (state == ST_IDLE);
  assign samples.ready = (state == ST_IDLE) && !cfg.valid;
  assign accept        = samples.valid && samples.ready;
  assign commit        = (state == ST_DONE) && (!out_valid || results.ready);

  // Sample conditioning at accept time.
  assign in_cur  = clamp_sample(samples.sample_current, nom_i);
  assign in_volt = clamp_sample(samples.sample_voltage, nom_v);
  assign in_dt   = (samples.sample_time >= last_time) ? samples.sample_time - last_time : '0;
  assign in_hot  = (temperature >= amb);
  assign in_mag  = in_hot ? temperature - amb : amb - temperature;

  // Operand selection for the shared multiplier.
  assign fac = exp_factor(EXP_TAB_W'(j));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ: begin
        mul_a = MUL_W'(s);
        mul_b = MUL_W'(s);
      end
      ST_KDT: begin
        mul_a = MUL_W'(kcool);
        mul_b = dt;
      end
      ST_RLO: begin
        mul_a = MUL_W'(resistance);
        mul_b = ss[MUL_W-1:0];
      end
      ST_RHI: begin
        mul_a = MUL_W'(resistance);
        mul_b = MUL_W'(ss[SS_W-1:MUL_W]);
      end
      ST_CLO: begin
        mul_a = kd[MUL_W-1:0];
        mul_b = MUL_W'(mag);
      end
      ST_CHI: begin
        mul_a = MUL_W'(kd[KD_W-1:MUL_W]);
        mul_b = MUL_W'(mag);
      end
      ST_HLO: begin
        mul_a = p[MUL_W-1:0];
        mul_b = dt;
      end
      ST_HHI: begin
        mul_a = MUL_W'(p[P_W-1:MUL_W]);
        mul_b = dt;
      end
      ST_XMUL: begin
        mul_a = MUL_W'(alpha);
        mul_b = MUL_W'(tnew);
      end
      ST_EXP: begin
        mul_a = e;
        mul_b = fac;
      end
      ST_RMUL: begin
        mul_a = MUL_W'(r0);
        mul_b = e;
      end
      default: ;
    endcase
  end

  pste_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Recombination of split products.
  assign p_sum    = acc[PS_W-1:0] + {prod[PS_W-MUL_W-1:0], {MUL_W{1'b0}}};
  assign cool_sum = acc[CS_W-1:0] + {prod[CS_W-MUL_W-1:0], {MUL_W{1'b0}}};
  assign heat_sum = HS_W'(acc) + {prod[HS_W-MUL_W-1:0], {MUL_W{1'b0}}};

  // Temperature step: old temperature moved by cooling, then heating added.
  assign t_ext    = TC_W'(temperature);
  assign cool_ext = TC_W'(cool);
  assign nt_sum   = {tc[TC_W-1], tc} + NT_W'(heat);

  always_comb begin
    if (nt_sum[NT_W-1]) begin
      t_sat = '0;
    end else if (nt_sum[NT_W-2:TEMP_W] != '0) begin
      t_sat = '1;
    end else begin
      t_sat = nt_sum[TEMP_W-1:0];
    end
  end

  // Exponent and its loop control.
  assign x_next = prod[X_W+15:16];
  assign x_ovf  = (x_next >> EXP_STEPS) != '0;
  assign e_rnd  = prod + (PROD_W'(1) << (MUL_W - 1));
  assign j_last = (j == EXP_IDX_W'(EXP_BITS - 1));

  // Resistance: R0 * (2 - e), rounded half up.
  assign r0e   = e_one ? {r0, {MUL_W{1'b0}}} : prod[RE_W-1:0];
  assign r_sum = {1'b0, r0, 33'd0} - RS_W'(r0e) + (RS_W'(1) << 31);

  // Sequencer, configuration registers and model state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      e_one       <= 1'b1;
      j           <= '0;
      nom_i       <= NOM_CURRENT_RST;
      nom_v       <= NOM_VOLTAGE_RST;
      amb         <= AMBIENT_RST;
      r0          <= BASE_RES_RST;
      kcool       <= COOLING_RST;
      alpha       <= ALPHA_RST;
      temperature <= AMBIENT_RST;
      resistance  <= RES_W'(BASE_RES_RST);
      prev_cur    <= '0;
      last_time   <= '0;
    end else begin
      // Register writes.
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_NOM_CURRENT: nom_i <= cfg.data[NOM_W-1:0];
          REG_NOM_VOLTAGE: nom_v <= cfg.data[NOM_W-1:0];
          REG_AMBIENT:     amb   <= cfg.data[TEMP_W-1:0];
          REG_BASE_RES:    r0    <= cfg.data[RES0_W-1:0];
          REG_COOLING:     kcool <= cfg.data[KCOOL_W-1:0];
          REG_ALPHA:       alpha <= cfg.data[ALPHA_W-1:0];
          default: ;
        endcase
      end

      // The output slot empties when its request is taken.
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SQ;
          end
        end
        ST_SQ:   state <= ST_KDT;
        ST_KDT:  state <= ST_RLO;
        ST_RLO:  state <= ST_RHI;
        ST_RHI:  state <= ST_CLO;
        ST_CLO:  state <= ST_CHI;
        ST_CHI:  state <= ST_HLO;
        ST_HLO:  state <= ST_HHI;
        ST_HHI:  state <= ST_HEAT;
        ST_HEAT: state <= ST_TEMP;
        ST_TEMP: state <= ST_XMUL;
        ST_XMUL: state <= ST_XGET;
        ST_XGET: begin
          j <= '0;
          if (x_ovf) begin
            e_one <= 1'b0;
            state <= ST_RMUL;
          end else begin
            e_one <= 1'b1;
            state <= ST_EXP;
          end
        end
        ST_EXP: begin
          if (x[j] && !e_one) begin
            state <= ST_ERND;
          end else begin
            // First set bit loads its factor directly; clear bits pass.
            if (x[j]) begin
              e_one <= 1'b0;
            end
            if (j_last) begin
              state <= ST_RMUL;
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        ST_ERND: begin
          if (j_last) begin
            state <= ST_RMUL;
          end else begin
            j     <= j + 1'b1;
            state <= ST_EXP;
          end
        end
        ST_RMUL: state <= ST_RFIN;
        ST_RFIN: state <= ST_DONE;
        ST_DONE: begin
          if (commit) begin
            out_valid   <= 1'b1;
            temperature <= tnew;
            resistance  <= rnew;
            prev_cur    <= cur;
            last_time   <= tm;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers, loaded by the step that produces them.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          dev     <= samples.device_id;
          stepn   <= samples.step_number;
          tm      <= samples.sample_time;
          cur     <= in_cur;
          volt    <= in_volt;
          cur_hi  <= (in_cur > CLAMP_W'(nom_i));
          volt_hi <= (in_volt > CLAMP_W'(nom_v));
          s       <= SUM_W'(prev_cur) + SUM_W'(in_cur);
          dt      <= in_dt;
          hot     <= in_hot;
          mag     <= in_mag;
        end
      end
      ST_KDT:  ss   <= prod[SS_W-1:0];
      ST_RLO:  kd   <= prod[KD_W+15:16];
      ST_RHI:  acc  <= prod;
      ST_CLO:  p    <= p_sum[PS_W-1:26];
      ST_CHI:  acc  <= prod;
      ST_HLO:  cool <= cool_sum[CS_W-1:16];
      ST_HHI: begin
        acc <= prod;
        tc  <= hot ? t_ext - cool_ext : t_ext + cool_ext;
      end
      ST_HEAT: heat <= heat_sum[HS_W-1:24];
      ST_TEMP: tnew <= t_sat;
      ST_XGET: begin
        x <= x_next;
        if (x_ovf) begin
          e <= '0;
        end
      end
      ST_EXP: begin
        if (x[j] && e_one) begin
          e <= fac;
        end
      end
      ST_ERND: e    <= e_rnd[PROD_W-1:MUL_W];
      ST_RFIN: rnew <= r_sum[RES_W+31:32];
      default: ;
    endcase

    // Result payload.
    if (commit) begin
      out_dev     <= dev;
      out_step    <= stepn;
      out_time    <= tm;
      out_cur     <= cur;
      out_volt    <= volt;
      out_temp    <= tnew;
      out_res     <= rnew;
      out_cur_hi  <= cur_hi;
      out_volt_hi <= volt_hi;
    end
  end

  assign results.valid           = out_valid;
  assign results.device_out      = out_dev;
  assign results.step_out        = out_step;
  assign results.time_out        = out_time;
  assign results.clamped_current = out_cur;
  assign results.clamped_voltage = out_volt;
  assign results.temperature_out = out_temp;
  assign results.resistance_out  = out_res;
  assign results.current_high    = out_cur_hi;
  assign results.voltage_high    = out_volt_hi;

endmodule

// ===== hw/rtl/pste_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
module pste_mul import pste_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] prod
);

  // The product is registered: it appears on prod in the cycle after the operands are presented.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== hw/rtl/pste_checker.sv =====
// Port-level checks of the power switch thermal estimator and their binding.
module pste_checker import pste_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DEV_W-1:0]   device_out,
  input logic [STEP_W-1:0]  step_out,
  input logic [TEMP_W-1:0]  temperature_out,
  input logic [RES_W-1:0]   resistance_out
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] outstanding;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Samples taken whose results have not yet been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 2'(in_acc) - 2'(out_acc);
    end
  end

  // One sample at a time: the block is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("sample taken while the previous one was still in work");

  // A result is only offered for a sample that was taken.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != 2'd0)
    else $error("result offered without a pending sample");

  // At most one sample in work plus one result waiting.
  a_bounded_backlog: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("more than two samples pending");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(device_out) && $stable(step_out)
      && $stable(temperature_out) && $stable(resistance_out))
    else $error("stalled result changed");

endmodule

bind power_switch_thermal_estimator pste_checker u_pste_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (samples.valid),
  .in_ready        (samples.ready),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .device_out      (results.device_out),
  .step_out        (results.step_out),
  .temperature_out (results.temperature_out),
  .resistance_out  (results.resistance_out)
);

// ===== tb/sv/pste_tb_pkg.sv =====
// Request types and the scoreboard of the power switch thermal estimator testbench.
package pste_tb_pkg;
  import pste_pkg::*;

  // Register indexes that map to no register; writes to them change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint unsigned TEMP_CEIL = (64'd1 << TEMP_W) - 1;
  localparam longint unsigned RES_MASK  = (64'd1 << RES_W) - 1;
  localparam longint unsigned ONE_Q32   = 64'd1 << 32;
  localparam longint unsigned HALF_Q32  = 64'd1 << 31;

  // exp(-2^(j-16)) in Q32 for exponent bits 0..20, bit 0 rightmost.
  localparam logic [20:0][31:0] DECAY_Q32 = {
    32'd483,        32'd1440801,    32'd78665070,   32'd581260615,
    32'd1580030169, 32'd2605029347, 32'd3344923893, 32'd3790295335,
    32'd4034748382, 32'd4162825044, 32'd4228380000, 32'd4261543595,
    32'd4278222805, 32'd4286586875, 32'd4290775039, 32'd4292870656,
    32'd4293918848, 32'd4294443040, 32'd4294705160, 32'd4294836226,
    32'd4294901760
  };

  typedef struct packed {
    logic [DEV_W-1:0]       device_id;
    logic [STEP_W-1:0]      step_number;
    logic [TIME_W-1:0]      sample_time;
    logic [SAMPLE_BITS-1:0] sample_current;
    logic [SAMPLE_BITS-1:0] sample_voltage;
  } sample_t;

  typedef struct packed {
    logic [DEV_W-1:0]   device_out;
    logic [STEP_W-1:0]  step_out;
    logic [TIME_W-1:0]  time_out;
    logic [CLAMP_W-1:0] clamped_current;
    logic [CLAMP_W-1:0] clamped_voltage;
    logic [TEMP_W-1:0]  temperature_out;
    logic [RES_W-1:0]   resistance_out;
    logic               current_high;
    logic               voltage_high;
  } result_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] nom_current;
    logic [CFG_DATA_W-1:0] nom_voltage;
    logic [CFG_DATA_W-1:0] ambient;
    logic [CFG_DATA_W-1:0] base_res;
    logic [CFG_DATA_W-1:0] cooling;
    logic [CFG_DATA_W-1:0] alpha;
  } settings_t;

  // Tracks the thermal state of the switch and the results it still owes.
  class thermal_tracker;
    longint unsigned nom_current, nom_voltage, ambient, base_res, cooling, alpha;
    longint unsigned temperature, resistance, prev_current, last_time;
    result_t         awaited[$];
    int unsigned     mismatches;
    int unsigned     compared;

    function new();
      nom_current  = NOM_CURRENT_RST;
      nom_voltage  = NOM_VOLTAGE_RST;
      ambient      = AMBIENT_RST;
      base_res     = BASE_RES_RST;
      cooling      = COOLING_RST;
      alpha        = ALPHA_RST;
      temperature  = ambient;
      resistance   = base_res;
      prev_current = 0;
      last_time    = 0;
      mismatches   = 0;
      compared     = 0;
    endfunction

    // Registers keep only their own width; the state is not reloaded.
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_NOM_CURRENT: nom_current = value[NOM_W-1:0];
        REG_NOM_VOLTAGE: nom_voltage = value[NOM_W-1:0];
        REG_AMBIENT:     ambient     = value[TEMP_W-1:0];
        REG_BASE_RES:    base_res    = value[RES0_W-1:0];
        REG_COOLING:     cooling     = value[KCOOL_W-1:0];
        REG_ALPHA:       alpha       = value[ALPHA_W-1:0];
        default: ;
      endcase
    endfunction

    // Negative readings read as zero, readings past twice nominal as twice nominal.
    function longint unsigned clamp_level(logic [SAMPLE_BITS-1:0] raw, longint unsigned nominal);
      longint unsigned limit;
      limit = nominal << 1;
      if (raw[SAMPLE_BITS-1]) return 0;
      return (raw > limit) ? limit : longint'(raw);
    endfunction

    // exp(-x) in Q32 for a Q16 exponent, one rounded product per set bit.
    function longint unsigned decay_q32(longint unsigned x);
      longint unsigned e;
      longint unsigned factor;
      e = ONE_Q32;
      if ((x >> EXP_STEPS) != 0) return 0;
      for (int j = 0; j < EXP_STEPS && j < 48; j++) begin
        if (x[j]) begin
          factor = (j <= 20) ? longint'(DECAY_Q32[j]) : 0;
          e = (e * factor + HALF_Q32) >> 32;
        end
      end
      return e;
    endfunction

    // Advances the thermal state by one accepted sample and queues its result.
    function void take_sample(sample_t s);
      longint unsigned tm, cur, volt, dt, sum, pwr, part_hi, part_lo, heat;
      longint unsigned mag, kd, cool, x, e;
      longint          nt;
      bit              hot;
      result_t         want;
      tm   = s.sample_time;
      cur  = clamp_level(s.sample_current, nom_current);
      volt = clamp_level(s.sample_voltage, nom_voltage);

      // A timestamp that goes backwards gives no elapsed time.
      dt = (tm >= last_time) ? tm - last_time : 0;
      last_time = tm;

      // Joule heating from the mean of the previous and present currents.
      sum     = prev_current + cur;
      pwr     = (resistance * (sum * sum)) >> 26;
      part_hi = pwr * (dt >> 16);
      part_lo = pwr * (dt & 64'hFFFF);
      heat    = (part_hi >> 8) + ((((part_hi & 64'hFF) << 16) + part_lo) >> 24);

      // Newtonian cooling toward the ambient temperature.
      hot  = temperature >= ambient;
      mag  = hot ? temperature - ambient : ambient - temperature;
      kd   = (cooling * dt) >> 16;
      cool = (kd * mag) >> 16;

      nt = longint'(temperature) + longint'(heat);
      nt = hot ? nt - longint'(cool) : nt + longint'(cool);
      if (nt < 0) nt = 0;
      if (nt > longint'(TEMP_CEIL)) nt = longint'(TEMP_CEIL);
      temperature  = longint'(nt);
      prev_current = cur;

      // On-resistance rises with temperature as R0 * (2 - exp(-alpha*T)).
      x = (alpha * temperature) >> 16;
      e = decay_q32(x);
      resistance = ((base_res * ((ONE_Q32 << 1) - e) + HALF_Q32) >> 32) & RES_MASK;

      want.device_out      = s.device_id;
      want.step_out        = s.step_number;
      want.time_out        = s.sample_time;
      want.clamped_current = CLAMP_W'(cur);
      want.clamped_voltage = CLAMP_W'(volt);
      want.temperature_out = TEMP_W'(temperature);
      want.resistance_out  = RES_W'(resistance);
      want.current_high    = cur > nom_current;
      want.voltage_high    = volt > nom_voltage;
      awaited.push_back(want);
    endfunction

    function void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result %0d: %s expected 0x%0h, got 0x%0h", compared, field, want, got);
      end
    endfunction

    // Compares one accepted result request with the oldest outstanding one.
    function void match_result(result_t got);
      result_t want;
      compared++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result %0d: device %0d step %0d arrived with none outstanding",
                   compared, got.device_out, got.step_out);
        return;
      end
      want = awaited.pop_front();
      check_field("device_out", want.device_out, got.device_out);
      check_field("step_out", want.step_out, got.step_out);
      check_field("time_out", want.time_out, got.time_out);
      check_field("clamped_current", want.clamped_current, got.clamped_current);
      check_field("clamped_voltage", want.clamped_voltage, got.clamped_voltage);
      check_field("temperature_out", want.temperature_out, got.temperature_out);
      check_field("resistance_out", want.resistance_out, got.resistance_out);
      check_field("current_high", want.current_high, got.current_high);
      check_field("voltage_high", want.voltage_high, got.voltage_high);
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top level of the power switch thermal estimator testbench: stimulus, idling and checking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pste_pkg::*;
  import pste_tb_pkg::*;

  localparam int DRAIN_CYCLES = 100;

  logic clk;
  logic rst;

  pste_cfg_if cfg_ch ();
  pste_in_if  sample_ch ();
  pste_out_if result_ch ();

  power_switch_thermal_estimator i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (sample_ch),
    .results (result_ch)
  );

  thermal_tracker         tracker;
  int unsigned            send_idle_pct;
  int unsigned            take_idle_pct;
  int unsigned            samples_sent;
  int unsigned            settings_loaded;
  logic [TIME_W-1:0]      clock_stamp;
  logic [STEP_W-1:0]      step_seq;

  // Clock, 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result side: check each accepted result request, then stall at random.
  always @(posedge clk) begin : take_results
    result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.device_out      = result_ch.device_out;
      got.step_out        = result_ch.step_out;
      got.time_out        = result_ch.time_out;
      got.clamped_current = result_ch.clamped_current;
      got.clamped_voltage = result_ch.clamped_voltage;
      got.temperature_out = result_ch.temperature_out;
      got.resistance_out  = result_ch.resistance_out;
      got.current_high    = result_ch.current_high;
      got.voltage_high    = result_ch.voltage_high;
      tracker.match_result(got);
    end
    result_ch.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  function automatic sample_t sample_of(logic [DEV_W-1:0] dev, logic [STEP_W-1:0] num,
                                        logic [TIME_W-1:0] tm, logic [SAMPLE_BITS-1:0] cur,
                                        logic [SAMPLE_BITS-1:0] volt);
    sample_t s;
    s.device_id      = dev;
    s.step_number    = num;
    s.sample_time    = tm;
    s.sample_current = cur;
    s.sample_voltage = volt;
    return s;
  endfunction

  // Mostly in-range readings, with negatives, overloads and the clamp edges mixed in.
  function automatic logic [SAMPLE_BITS-1:0] pick_level(longint unsigned nominal);
    int unsigned sel;
    int unsigned limit;
    sel   = $urandom_range(99);
    limit = int'(nominal << 1);
    if (sel < 65) return SAMPLE_BITS'($urandom_range(0, limit));
    if (sel < 75) return {1'b1, (SAMPLE_BITS-1)'($urandom)};
    if (sel < 85) return SAMPLE_BITS'($urandom_range(limit, (1 << (SAMPLE_BITS-1)) - 1));
    if (sel < 93) begin
      case ($urandom_range(3))
        0:       return SAMPLE_BITS'(nominal);
        1:       return SAMPLE_BITS'(nominal + 1);
        2:       return SAMPLE_BITS'(limit);
        default: return SAMPLE_BITS'(limit + 1);
      endcase
    end
    return SAMPLE_BITS'($urandom);
  endfunction

  // Offers one sample request, idling first at random; valid stays high after acceptance.
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.device_id      <= s.device_id;
    sample_ch.step_number    <= s.step_number;
    sample_ch.sample_time    <= s.sample_time;
    sample_ch.sample_current <= s.sample_current;
    sample_ch.sample_voltage <= s.sample_voltage;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    tracker.take_sample(s);
    samples_sent++;
  endtask

  // Writes one register; the caller lowers valid after its last write.
  task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.write_register(idx, value);
  endtask

  task automatic apply_settings(input settings_t p);
    put_register(REG_NOM_CURRENT, p.nom_current);
    put_register(REG_NOM_VOLTAGE, p.nom_voltage);
    put_register(REG_AMBIENT, p.ambient);
    put_register(REG_BASE_RES, p.base_res);
    put_register(REG_COOLING, p.cooling);
    put_register(REG_ALPHA, p.alpha);
    cfg_ch.valid <= 1'b0;
    settings_loaded++;
  endtask

  // Waits for every outstanding result, then for the block to settle.
  task automatic wait_drained();
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Directed samples at the reset settings: field extremes, clamp edges, time jumps.
  task automatic directed_samples();
    logic [SAMPLE_BITS-1:0] nc;
    logic [SAMPLE_BITS-1:0] nv;
    nc = SAMPLE_BITS'(tracker.nom_current);
    nv = SAMPLE_BITS'(tracker.nom_voltage);
    send_sample(sample_of(8'd0, 16'd0, 32'd0, '0, '0));
    send_sample(sample_of(8'd255, 16'hFFFF, 32'd1311, nc, nv));
    send_sample(sample_of(8'd1, 16'd2, 32'd2622, nc + 1'b1, nv + 1'b1));
    send_sample(sample_of(8'd2, 16'd3, 32'd3933, nc << 1, nv << 1));
    send_sample(sample_of(8'd3, 16'd4, 32'd5244, (nc << 1) + 1'b1, (nv << 1) + 1'b1));
    // Largest positive, most negative and minus one.
    send_sample(sample_of(8'd4, 16'd5, 32'd6555, 20'h7FFFF, 20'h7FFFF));
    send_sample(sample_of(8'd5, 16'd6, 32'd7866, 20'h80000, 20'h80000));
    send_sample(sample_of(8'd6, 16'd7, 32'd9177, 20'hFFFFF, 20'hFFFFF));
    // Time going backwards, then standing still.
    send_sample(sample_of(8'd7, 16'd8, 32'd9000, nc << 1, nv));
    send_sample(sample_of(8'd8, 16'd9, 32'd9000, nc, nv << 1));
    // A long step at full current heats hard.
    send_sample(sample_of(8'd9, 16'd10, 32'h0100_2328, nc << 1, nv << 1));
    send_sample(sample_of(8'd10, 16'd11, 32'hFFFF_FFFF, 20'h7FFFF, 20'h55555));
    send_sample(sample_of(8'd11, 16'd12, 32'd0, 20'h2AAAA, 20'hAAAAA));
    clock_stamp = '0;
    step_seq    = 16'd12;
    for (int n = 0; n < 8; n++) begin
      clock_stamp = clock_stamp + 32'd1311;
      step_seq    = step_seq + 1'b1;
      send_sample(sample_of(DEV_W'(n * 31), step_seq, clock_stamp,
                            SAMPLE_BITS'(n * 19000), SAMPLE_BITS'(n * 12000)));
    end
    sample_ch.valid <= 1'b0;
  endtask

  // Main sequence.
  initial begin
    settings_t plan;
    int        count;
    sample_t   s;
    int unsigned sel;
    tracker = new();
    rst                      = 1'b1;
    cfg_ch.valid             = 1'b0;
    cfg_ch.index             = '0;
    cfg_ch.data              = '0;
    sample_ch.valid          = 1'b0;
    sample_ch.device_id      = '0;
    sample_ch.step_number    = '0;
    sample_ch.sample_time    = '0;
    sample_ch.sample_current = '0;
    sample_ch.sample_voltage = '0;
    result_ch.ready          = 1'b0;
    send_idle_pct            = 27;
    take_idle_pct            = 64;
    samples_sent             = 0;
    settings_loaded          = 1;
    clock_stamp              = '0;
    step_seq                 = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Writes to unmapped indexes must leave every register alone.
    put_register(REG_SPARE_LO, CFG_DATA_W'($urandom));
    put_register(REG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;

    directed_samples();
    wait_drained();

    for (int seg = 0; seg < 6; seg++) begin
      // Receiver idles more first, then the sender, then neither.
      if (seg < 2) begin
        send_idle_pct = 27;
        take_idle_pct = 64;
      end else if (seg < 4) begin
        send_idle_pct = 64;
        take_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end

      case (seg)
        0: count = 350;
        1: begin
          plan  = '1;
          count = 150;
          apply_settings(plan);
        end
        2: begin
          plan  = '0;
          count = 150;
          apply_settings(plan);
        end
        3: begin
          plan.nom_current = CFG_DATA_W'($urandom);
          plan.nom_voltage = CFG_DATA_W'($urandom);
          plan.ambient     = CFG_DATA_W'($urandom);
          plan.base_res    = CFG_DATA_W'($urandom);
          plan.cooling     = CFG_DATA_W'($urandom);
          plan.alpha       = CFG_DATA_W'($urandom);
          count = 400;
          apply_settings(plan);
        end
        default: begin
          // Plausible operating points that keep temperature and exponent moving.
          plan.nom_current = CFG_DATA_W'($urandom_range(1000, 150000));
          plan.nom_voltage = CFG_DATA_W'($urandom_range(1000, 150000));
          plan.ambient     = CFG_DATA_W'($urandom_range(50000, 100000));
          plan.base_res    = CFG_DATA_W'($urandom_range(1000, 200000));
          plan.cooling     = CFG_DATA_W'($urandom_range(0, 200000));
          plan.alpha       = CFG_DATA_W'($urandom_range(0, 1 << 20));
          count = (seg == 4) ? 400 : 350;
          apply_settings(plan);
        end
      endcase

      for (int n = 0; n < count; n++) begin
        // Mostly steady sampling, with long gaps, backward steps and wild stamps.
        sel = $urandom_range(99);
        if (sel < 70) clock_stamp = clock_stamp + $urandom_range(0, 4000);
        else if (sel < 82) clock_stamp = clock_stamp + $urandom_range(4001, 1 << 22);
        else if (sel < 88) clock_stamp = clock_stamp - $urandom_range(1, 1 << 20);
        else if (sel >= 92) clock_stamp = TIME_W'($urandom);
        step_seq = ($urandom_range(9) == 0) ? STEP_W'($urandom) : step_seq + 1'b1;
        s = sample_of(DEV_W'($urandom), step_seq, clock_stamp,
                      pick_level(tracker.nom_current), pick_level(tracker.nom_voltage));
        send_sample(s);
      end
      sample_ch.valid <= 1'b0;
      wait_drained();
    end

    $display("Drove %0d samples under %0d register settings, from zero to full scale.",
             samples_sent, settings_loaded);
    $display("Compared %0d results: %0d field mismatches, %0d results missing.",
             tracker.compared, tracker.mismatches, tracker.awaited.size());
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #(4_000_000);
    $display("Run limit reached with %0d results outstanding.", tracker.awaited.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== power_switch_thermal_estimator.f =====
hw/rtl/pste_pkg.sv
hw/rtl/pste_cfg_if.sv
hw/rtl/pste_in_if.sv
hw/rtl/pste_out_if.sv
hw/rtl/pste_mul.sv
hw/rtl/power_switch_thermal_estimator.sv
hw/rtl/pste_checker.sv
tb/sv/pste_tb_pkg.sv
tb/sv/tb_top.sv
